>>> sv/isc_pkg.sv
// Package for the indexed sequence store: sizes, opcodes and the cell command.
// No dependencies; every other file of the block uses it.
`default_nettype none
package isc_pkg;

	localparam int CAPACITY = 256;
	localparam int VAL_W    = 32;
	localparam int DATA_W   = 32;
	localparam int OP_W     = 4;
	localparam int POS_W    = 9;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int GRP      = 16;
	localparam int NGRP     = CAPACITY / GRP;

	localparam logic [OP_W-1:0] OP_INSERT     = 4'd0;
	localparam logic [OP_W-1:0] OP_REMOVE     = 4'd1;
	localparam logic [OP_W-1:0] OP_READ       = 4'd2;
	localparam logic [OP_W-1:0] OP_WRITE      = 4'd3;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd4;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd5;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd6;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd7;
	localparam logic [OP_W-1:0] OP_PEEK_FRONT = 4'd8;
	localparam logic [OP_W-1:0] OP_PEEK_BACK  = 4'd9;
	localparam logic [OP_W-1:0] OP_CLEAR      = 4'd10;

	typedef enum logic [1:0] {
		K_NONE,
		K_INS,
		K_REM,
		K_WR
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               rd;
		logic [IDX_W-1:0]   idx;
		logic [VAL_W-1:0]   value;
	} cmd_t;

endpackage
`default_nettype wire

>>> sv/isc_if.sv
// Handshake channels of the indexed sequence store: request and response.
// Depends on isc_pkg for field widths.
`default_nettype none
interface isc_req_if;
	logic                          valid;
	logic                          ready;
	logic [isc_pkg::OP_W-1:0]      opcode;
	logic [isc_pkg::POS_W-1:0]     position;
	logic [isc_pkg::DATA_W-1:0]    data_in;

	modport source (output valid, output opcode, output position, output data_in,
		input ready);
	modport sink (input valid, input opcode, input position, input data_in,
		output ready);
endinterface

interface isc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [isc_pkg::DATA_W-1:0]    data_out;
	logic [isc_pkg::CNT_W-1:0]     element_count;

	modport source (output valid, output ok, output data_out, output element_count,
		input ready);
	modport sink (input valid, input ok, input data_out, input element_count,
		output ready);
endinterface
`default_nettype wire

>>> sv/isc_cell.sv
// One storage cell of the shifting chain: holds one element, takes its
// neighbor's value on insert or remove. Depends on isc_pkg.
`default_nettype none
module isc_cell (
	input  wire logic                        clk,
	input  wire isc_pkg::cmd_t               cmd,
	input  wire logic [isc_pkg::IDX_W-1:0]   idx,
	input  wire logic [isc_pkg::VAL_W-1:0]   left_val,
	input  wire logic [isc_pkg::VAL_W-1:0]   right_val,
	output logic      [isc_pkg::VAL_W-1:0]   val,
	output logic      [isc_pkg::VAL_W-1:0]   tap
);

	logic [isc_pkg::VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			isc_pkg::K_INS: begin
				if (idx == cmd.idx) begin
					val_q <= cmd.value;
				end else if (idx > cmd.idx) begin
					val_q <= left_val;
				end
			end
			isc_pkg::K_REM: begin
				if (idx >= cmd.idx) begin
					val_q <= right_val;
				end
			end
			isc_pkg::K_WR: begin
				if (idx == cmd.idx) begin
					val_q <= cmd.value;
				end
			end
			isc_pkg::K_NONE: begin
			end
		endcase
	end

	assign val = val_q;
	assign tap = (cmd.rd && (idx == cmd.idx)) ? val_q : '0;

endmodule
`default_nettype wire

>>> sv/isc_gather.sv
// Two-level registered OR tree that collects the one selected cell value.
// Depends on isc_pkg.
`default_nettype none
module isc_gather (
	input  wire logic                                          clk,
	input  wire logic                                          ld_s1,
	input  wire logic                                          ld_s2,
	input  wire logic [isc_pkg::CAPACITY-1:0][isc_pkg::VAL_W-1:0] taps,
	output logic      [isc_pkg::VAL_W-1:0]                     data
);

	logic [isc_pkg::NGRP-1:0][isc_pkg::VAL_W-1:0] grp_d;
	logic [isc_pkg::NGRP-1:0][isc_pkg::VAL_W-1:0] grp_s1;
	logic [isc_pkg::VAL_W-1:0]                    all_d;
	logic [isc_pkg::VAL_W-1:0]                    data_q;

	always_comb begin
		for (int g = 0; g < isc_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < isc_pkg::GRP; k++) begin
				grp_d[g] = grp_d[g] | taps[g*isc_pkg::GRP + k];
			end
		end
	end

	always_comb begin
		all_d = '0;
		for (int g = 0; g < isc_pkg::NGRP; g++) begin
			all_d = all_d | grp_s1[g];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			grp_s1 <= grp_d;
		end
		if (ld_s2) begin
			data_q <= all_d;
		end
	end

	assign data = data_q;

endmodule
`default_nettype wire

>>> sv/indexed_sequence_store_core.sv
// Top level of the indexed sequence store: request decode, element count,
// chain of isc_cell and the isc_gather read tree. Depends on isc_pkg, isc_if.
//
//   channel  dir  beat payload
//   req      in   opcode, position, data_in
//   rsp      out  ok, data_out, element_count
//
// One request at a time: accept, then the cell update together with the first
// OR-tree stage, then the second OR-tree stage, then the response beat is offered.
// On insert or remove the cell chain shifts all later elements at once.
// A stalled response holds its beat; req.ready stays low until it is taken.
// arst_n clears the count and the control flags; cell contents are not reset.
`default_nettype none
module indexed_sequence_store_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	isc_req_if.sink    req,
	isc_rsp_if.source  rsp
);

	logic [isc_pkg::CNT_W-1:0] count_q;
	logic                      busy_q;
	logic                      v_s1;
	logic                      v_s2;
	logic                      out_vld_q;
	logic                      ok_q;
	logic [isc_pkg::CNT_W-1:0] cnt_q;
	isc_pkg::cmd_t             cmd_s1;

	isc_pkg::cmd_t             cmd_d;
	logic                      ok_d;
	logic [isc_pkg::CNT_W-1:0] cnt_d;
	logic                      full;
	logic                      empty;
	logic [isc_pkg::CNT_W-1:0] cnt_m1;
	logic [isc_pkg::CNT_W-1:0] cnt_p1;
	logic                      pos_lt;
	logic                      pos_le;
	logic                      accept;
	logic                      deliver;

	logic [isc_pkg::VAL_W-1:0]                         cell_val [isc_pkg::CAPACITY];
	logic [isc_pkg::CAPACITY-1:0][isc_pkg::VAL_W-1:0] taps;
	logic [isc_pkg::VAL_W-1:0]                         rd_data;

	assign accept  = req.valid && req.ready;
	assign deliver = rsp.valid && rsp.ready;
	assign req.ready = !busy_q;

	assign full   = (count_q == isc_pkg::CNT_W'(isc_pkg::CAPACITY));
	assign empty  = (count_q == '0);
	assign cnt_m1 = count_q - isc_pkg::CNT_W'(1);
	assign cnt_p1 = count_q + isc_pkg::CNT_W'(1);
	assign pos_lt = (isc_pkg::CNT_W'(req.position) < count_q);
	assign pos_le = (isc_pkg::CNT_W'(req.position) <= count_q);

	always_comb begin
		cmd_d.kind  = isc_pkg::K_NONE;
		cmd_d.rd    = 1'b0;
		cmd_d.idx   = req.position[isc_pkg::IDX_W-1:0];
		cmd_d.value = req.data_in[isc_pkg::VAL_W-1:0];
		ok_d        = 1'b0;
		cnt_d       = count_q;
		unique case (req.opcode)
			isc_pkg::OP_INSERT: begin
				ok_d       = pos_le && !full;
				cmd_d.kind = isc_pkg::K_INS;
				cnt_d      = cnt_p1;
			end
			isc_pkg::OP_REMOVE: begin
				ok_d       = pos_lt;
				cmd_d.kind = isc_pkg::K_REM;
				cmd_d.rd   = 1'b1;
				cnt_d      = cnt_m1;
			end
			isc_pkg::OP_READ: begin
				ok_d     = pos_lt;
				cmd_d.rd = 1'b1;
			end
			isc_pkg::OP_WRITE: begin
				ok_d       = pos_lt;
				cmd_d.kind = isc_pkg::K_WR;
			end
			isc_pkg::OP_PUSH_FRONT: begin
				ok_d       = !full;
				cmd_d.kind = isc_pkg::K_INS;
				cmd_d.idx  = '0;
				cnt_d      = cnt_p1;
			end
			isc_pkg::OP_PUSH_BACK: begin
				ok_d       = !full;
				cmd_d.kind = isc_pkg::K_INS;
				cmd_d.idx  = count_q[isc_pkg::IDX_W-1:0];
				cnt_d      = cnt_p1;
			end
			isc_pkg::OP_POP_FRONT: begin
				ok_d       = !empty;
				cmd_d.kind = isc_pkg::K_REM;
				cmd_d.rd   = 1'b1;
				cmd_d.idx  = '0;
				cnt_d      = cnt_m1;
			end
			isc_pkg::OP_POP_BACK: begin
				ok_d       = !empty;
				cmd_d.kind = isc_pkg::K_REM;
				cmd_d.rd   = 1'b1;
				cmd_d.idx  = cnt_m1[isc_pkg::IDX_W-1:0];
				cnt_d      = cnt_m1;
			end
			isc_pkg::OP_PEEK_FRONT: begin
				ok_d      = !empty;
				cmd_d.rd  = 1'b1;
				cmd_d.idx = '0;
			end
			isc_pkg::OP_PEEK_BACK: begin
				ok_d      = !empty;
				cmd_d.rd  = 1'b1;
				cmd_d.idx = cnt_m1[isc_pkg::IDX_W-1:0];
			end
			isc_pkg::OP_CLEAR: begin
				ok_d  = 1'b1;
				cnt_d = '0;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
		if (!ok_d || !accept) begin
			cmd_d.kind = isc_pkg::K_NONE;
			cmd_d.rd   = 1'b0;
			cnt_d      = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			busy_q       <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			out_vld_q    <= 1'b0;
			cmd_s1.kind  <= isc_pkg::K_NONE;
			cmd_s1.rd    <= 1'b0;
			cmd_s1.idx   <= '0;
			cmd_s1.value <= '0;
		end else begin
			v_s1         <= accept;
			v_s2         <= v_s1;
			cmd_s1.kind  <= cmd_d.kind;
			cmd_s1.rd    <= cmd_d.rd;
			cmd_s1.idx   <= cmd_d.idx;
			cmd_s1.value <= cmd_d.value;
			count_q      <= cnt_d;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (deliver) begin
				busy_q <= 1'b0;
			end
			if (v_s2) begin
				out_vld_q <= 1'b1;
			end else if (deliver) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q  <= ok_d;
			cnt_q <= cnt_d;
		end
	end

	for (genvar g = 0; g < isc_pkg::CAPACITY; g++) begin : g_cell
		logic [isc_pkg::VAL_W-1:0] left_val;
		logic [isc_pkg::VAL_W-1:0] right_val;

		if (g == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[g-1];
		end
		if (g == isc_pkg::CAPACITY - 1) begin : g_last
			assign right_val = cell_val[g];
		end else begin : g_mid_r
			assign right_val = cell_val[g+1];
		end

		isc_cell u_cell (
			.clk       (clk),
			.cmd       (cmd_s1),
			.idx       (isc_pkg::IDX_W'(g)),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[g]),
			.tap       (taps[g])
		);
	end

	isc_gather u_gather (
		.clk   (clk),
		.ld_s1 (v_s1),
		.ld_s2 (v_s2),
		.taps  (taps),
		.data  (rd_data)
	);

	assign rsp.valid         = out_vld_q;
	assign rsp.ok            = ok_q;
	assign rsp.data_out      = isc_pkg::DATA_W'(rd_data);
	assign rsp.element_count = cnt_q;

endmodule
`default_nettype wire
